### rtl/midi_note_to_tone_registers_unit_defines.svh
// Assertion macros for the MIDI note to tone register unit.
// Expects clk and rst_n in scope at the point of use; no other dependencies.
`ifndef MIDI_NOTE_TO_TONE_REGISTERS_UNIT_DEFINES_SVH
`define MIDI_NOTE_TO_TONE_REGISTERS_UNIT_DEFINES_SVH

// ante holds at an edge -> cons holds at the same edge
`define MNTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante holds at an edge -> cons holds at the next edge
`define MNTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// cond never holds
`define MNTR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/mntr_pkg.sv
// Shared types, constants and tone tables for the MIDI note to tone register unit.
// No dependencies.
package mntr_pkg;

  localparam int BYTE_W    = 8;
  localparam int NOTE_W    = 7;
  localparam int NIBBLE_W  = 4;
  localparam int PITCH_W   = 14;
  localparam int DIVIDEND_W = 17;
  localparam int QUOT_W    = 12;
  localparam int NUM_GROUPS = 5;
  localparam int GROUP_W   = 3;

  localparam logic [DIVIDEND_W-1:0] PSG_CLOCK = 17'd125000;

  localparam logic [NIBBLE_W-1:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [NIBBLE_W-1:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [NIBBLE_W-1:0] CMD_CONTROL  = 4'hB;
  localparam logic [NIBBLE_W-1:0] CMD_PROGRAM  = 4'hC;

  localparam logic [NIBBLE_W-1:0] CH_FM_LO = 4'd3;
  localparam logic [NIBBLE_W-1:0] CH_FM_HI = 4'd4;
  localparam logic [NIBBLE_W-1:0] CH_DRUM  = 4'd9;

  localparam logic [1:0] FM_CHIP = 2'd3;
  localparam logic [5:0] DRUM_ADDR     = 6'h0E;
  localparam logic [5:0] FM_FNUM_BASE  = 6'h10;
  localparam logic [5:0] FM_KEY_BASE   = 6'h20;
  localparam logic [7:0] FM_KEY_ON     = 8'h10;
  localparam logic [7:0] DRUM_RHYTHM   = 8'h40;

  localparam logic [NOTE_W-1:0] NOTE_BASS_DRUM = 7'h24;
  localparam logic [NOTE_W-1:0] NOTE_SNARE     = 7'h26;
  localparam logic [NOTE_W-1:0] NOTE_TOM       = 7'h2F;
  localparam logic [NOTE_W-1:0] NOTE_CYMBAL    = 7'h31;
  localparam logic [NOTE_W-1:0] NOTE_HIHAT     = 7'h2A;

  // note / 12 == (note * 43) >> 9 for every 7-bit note
  localparam logic [5:0] DIV12_MUL = 6'd43;
  localparam int         DIV12_SHR = 9;

  // packed so that chip sits in the lowest bits
  typedef struct packed {
    logic [7:0] reg_data;
    logic [5:0] reg_address;
    logic [1:0] target_chip;
  } write_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SQ,
    KIND_FM,
    KIND_DRUM
  } kind_t;

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_DATA1,
    PH_DATA2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CLAIM,
    ST_DIV,
    ST_SEND_LO,
    ST_SEND_HI
  } state_t;

  typedef struct packed {
    logic ld_status;
    logic ld_note;
    logic split;
    logic claim;
    logic ld_quot;
    logic send_hi;
  } dp_cmd_t;

  typedef struct packed {
    logic  status_ok;
    logic  pend_prog;
    logic  pend_noteon;
    kind_t kind;
    logic  found;
    logic  div_done;
  } dp_stat_t;

  function automatic logic [8:0] pitch_tab(input logic [3:0] tone);
    logic [8:0] p;
    unique case (tone)
      4'd0:    p = 9'd263;
      4'd1:    p = 9'd277;
      4'd2:    p = 9'd294;
      4'd3:    p = 9'd311;
      4'd4:    p = 9'd330;
      4'd5:    p = 9'd349;
      4'd6:    p = 9'd370;
      4'd7:    p = 9'd392;
      4'd8:    p = 9'd415;
      4'd9:    p = 9'd440;
      4'd10:   p = 9'd466;
      4'd11:   p = 9'd494;
      default: p = 9'd263;
    endcase
    return p;
  endfunction

  function automatic logic [8:0] fnum_tab(input logic [3:0] tone);
    logic [8:0] f;
    unique case (tone)
      4'd0:    f = 9'd172;
      4'd1:    f = 9'd181;
      4'd2:    f = 9'd191;
      4'd3:    f = 9'd204;
      4'd4:    f = 9'd216;
      4'd5:    f = 9'd229;
      4'd6:    f = 9'd242;
      4'd7:    f = 9'd257;
      4'd8:    f = 9'd272;
      4'd9:    f = 9'd288;
      4'd10:   f = 9'd305;
      4'd11:   f = 9'd323;
      default: f = 9'd172;
    endcase
    return f;
  endfunction

endpackage

### rtl/mntr_div.sv
// Restoring divider: constant PSG clock divided by a pitch, one quotient bit per cycle.
// Depends on mntr_pkg.
module mntr_div
  import mntr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PITCH_W-1:0] divisor,
  output logic               done,
  output logic [QUOT_W-1:0]  quot
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [PITCH_W-1:0]    rem_r, rem_nxt;
  logic [PITCH_W-1:0]    dsr_r, dsr_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic [PITCH_W:0]      trial;
  logic                  ge;

  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      dvd_nxt  = PSG_CLOCK;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      rem_nxt = ge ? PITCH_W'(trial - {1'b0, dsr_r}) : trial[PITCH_W-1:0];
      quo_nxt = {quo_r[QUOT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### rtl/mntr_dp.sv
// Datapath: message registers, note split, voice allocation, drum image, write words.
// Depends on mntr_pkg and mntr_div.
module mntr_dp
  import mntr_pkg::*;
#(
  parameter int VOICES_PER_GROUP = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_byte,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output write_t            out_word,
  output logic              out_last
);

  localparam int VW = (VOICES_PER_GROUP > 1) ? $clog2(VOICES_PER_GROUP) : 1;

  logic [NIBBLE_W-1:0] pend_cmd_r, pend_ch_r;
  logic [NOTE_W-1:0]   note_r;
  logic [3:0]          octq_r, tone_r;
  logic [VOICES_PER_GROUP-1:0] busy_r [NUM_GROUPS];
  logic [7:0]          drum_r, drum_nxt;
  logic [1:0]          voice_r;
  write_t              wr_lo_r, wr_hi_r;

  logic [NIBBLE_W-1:0] top;
  logic [12:0]         prod;
  logic [3:0]          octq;
  logic [NOTE_W-1:0]   tone_full;
  kind_t               kind;
  logic [GROUP_W-1:0]  grp;
  logic                found;
  logic [VW-1:0]       first;
  logic                take;
  logic [8:0]          ptab;
  logic [PITCH_W-1:0]  pitch;
  logic [2:0]          shl, shr;
  logic [8:0]          fnum;
  logic [2:0]          fm_oct;
  logic [2:0]          fm_voice;
  logic [1:0]          vnum;
  logic                div_start, div_done;
  logic [QUOT_W-1:0]   quot;
  logic [5:0]          sq_addr;

  assign top = in_byte[BYTE_W-1:BYTE_W-NIBBLE_W];

  assign prod      = {6'd0, note_r} * {7'd0, DIV12_MUL};
  assign octq      = prod[DIV12_SHR+3:DIV12_SHR];
  assign tone_full = note_r - NOTE_W'({octq, 3'd0} + {1'b0, octq, 2'd0});

  always_comb begin
    if (pend_ch_r <= 4'd2) begin
      kind = KIND_SQ;
    end else if (pend_ch_r == CH_FM_LO || pend_ch_r == CH_FM_HI) begin
      kind = KIND_FM;
    end else if (pend_ch_r == CH_DRUM) begin
      kind = KIND_DRUM;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign grp = pend_ch_r[GROUP_W-1:0];

  always_comb begin
    found = 1'b0;
    first = '0;
    if (kind == KIND_SQ || kind == KIND_FM) begin
      for (int i = 0; i < VOICES_PER_GROUP; i++) begin
        if (!busy_r[grp][i] && !found) begin
          found = 1'b1;
          first = VW'(i);
        end
      end
    end
  end

  assign take = cmd.claim && found;
  assign vnum = 2'(first);

  // square wave pitch, octave-scaled around octave 4 (octq 5)
  assign ptab  = pitch_tab(tone_r);
  assign shl   = 3'(octq_r - 4'd5);
  assign shr   = 3'(4'd5 - octq_r);
  assign pitch = (octq_r >= 4'd5) ? ({5'd0, ptab} << shl) : ({5'd0, ptab} >> shr);

  assign fnum   = fnum_tab(tone_r);
  assign fm_oct = (octq_r == 4'd0) ? 3'd0 : ((octq_r >= 4'd9) ? 3'd7 : 3'(octq_r - 4'd1));
  assign fm_voice = {1'b0, vnum} + ((pend_ch_r == CH_FM_HI) ? 3'd3 : 3'd0);

  always_comb begin
    drum_nxt = drum_r | DRUM_RHYTHM;
    case (note_r)
      NOTE_BASS_DRUM: drum_nxt = drum_nxt | 8'h20;
      NOTE_SNARE:     drum_nxt = drum_nxt | 8'h10;
      NOTE_TOM:       drum_nxt = drum_nxt | 8'h08;
      NOTE_CYMBAL:    drum_nxt = drum_nxt | 8'h04;
      NOTE_HIHAT:     drum_nxt = drum_nxt | 8'h02;
      default:        drum_nxt = drum_nxt;
    endcase
  end

  assign div_start = take && (kind == KIND_SQ);

  mntr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (pitch),
    .done    (div_done),
    .quot    (quot)
  );

  assign sq_addr = {3'd0, voice_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cmd_r <= '0;
      pend_ch_r  <= '0;
      note_r     <= '0;
      drum_r     <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        busy_r[g] <= '0;
      end
    end else begin
      if (cmd.ld_status) begin
        pend_cmd_r <= top;
        pend_ch_r  <= in_byte[NIBBLE_W-1:0];
      end
      if (cmd.ld_note) begin
        note_r <= in_byte[NOTE_W-1:0];
      end
      if (take) begin
        busy_r[grp][first] <= 1'b1;
      end
      if (cmd.claim && kind == KIND_DRUM) begin
        drum_r <= drum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      octq_r <= octq;
      tone_r <= tone_full[3:0];
    end
    if (take) begin
      voice_r <= vnum;
    end
    if (take && kind == KIND_FM) begin
      wr_lo_r <= '{reg_data: fnum[7:0], reg_address: FM_FNUM_BASE + {3'd0, fm_voice},
                   target_chip: FM_CHIP};
      wr_hi_r <= '{reg_data: FM_KEY_ON | {4'd0, fm_oct, fnum[8]},
                   reg_address: FM_KEY_BASE + {3'd0, fm_voice}, target_chip: FM_CHIP};
    end else if (cmd.claim && kind == KIND_DRUM) begin
      wr_hi_r <= '{reg_data: drum_nxt, reg_address: DRUM_ADDR, target_chip: FM_CHIP};
    end else if (cmd.ld_quot) begin
      wr_lo_r <= '{reg_data: quot[7:0], reg_address: sq_addr, target_chip: pend_ch_r[1:0]};
      wr_hi_r <= '{reg_data: {4'd0, quot[QUOT_W-1:8]}, reg_address: sq_addr | 6'd1,
                   target_chip: pend_ch_r[1:0]};
    end
  end

  assign stat.status_ok   = (top == CMD_NOTE_OFF) || (top == CMD_NOTE_ON) ||
                            (top == CMD_CONTROL) || (top == CMD_PROGRAM);
  assign stat.pend_prog   = (pend_cmd_r == CMD_PROGRAM);
  assign stat.pend_noteon = (pend_cmd_r == CMD_NOTE_ON);
  assign stat.kind        = kind;
  assign stat.found       = found;
  assign stat.div_done    = div_done;

  assign out_word = cmd.send_hi ? wr_hi_r : wr_lo_r;
  assign out_last = cmd.send_hi;

endmodule

### rtl/mntr_ctrl.sv
// Controller: MIDI parse phase and the per-message sequencer with the stream handshakes.
// Depends on mntr_pkg.
module mntr_ctrl
  import mntr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_STATUS;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (phase_r)
            PH_STATUS: begin
              if (stat.status_ok) begin
                cmd.ld_status = 1'b1;
                phase_nxt     = PH_DATA1;
              end
            end
            PH_DATA1: begin
              cmd.ld_note = 1'b1;
              phase_nxt   = stat.pend_prog ? PH_STATUS : PH_DATA2;
            end
            PH_DATA2: begin
              phase_nxt = PH_STATUS;
              if (stat.pend_noteon) begin
                state_nxt = ST_SPLIT;
              end
            end
            default: phase_nxt = PH_STATUS;
          endcase
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_CLAIM;
      end
      ST_CLAIM: begin
        cmd.claim = 1'b1;
        if (stat.kind == KIND_SQ && stat.found) begin
          state_nxt = ST_DIV;
        end else if (stat.kind == KIND_FM && stat.found) begin
          state_nxt = ST_SEND_LO;
        end else if (stat.kind == KIND_DRUM) begin
          state_nxt = ST_SEND_HI;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.ld_quot = 1'b1;
          state_nxt   = ST_SEND_LO;
        end
      end
      ST_SEND_LO: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_SEND_HI;
        end
      end
      ST_SEND_HI: begin
        out_tvalid  = 1'b1;
        cmd.send_hi = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/midi_note_to_tone_registers_unit.sv
// Top level: MIDI byte stream in, sound-chip register writes out.
// Depends on mntr_pkg, mntr_ctrl, mntr_dp and the assertion macro header.
//
//  channel  dir  ports                                  payload
//  in_      in   in_tvalid/in_tready/in_tdata           rx_byte
//  out_     out  out_tvalid/out_tready/out_tdata/tlast  target_chip, reg_address, reg_data; tlast
//
// A byte that completes no note-on is taken while idle. A square-wave note-on
// runs split, claim, the 17-step serial divider and two writes, plus output stalls;
// an FM note-on skips the divider, a drum note-on makes one write. One byte is in work at a time.
// Synchronous active-low reset frees all voices and clears the drum image.
`include "midi_note_to_tone_registers_unit_defines.svh"

module midi_note_to_tone_registers_unit
  import mntr_pkg::*;
#(
  parameter int VOICES_PER_GROUP = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] target_chip, [7:2] reg_address, [15:8] reg_data
  output logic        out_tlast   // last_write
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  write_t   out_word;
  logic     out_last;

  mntr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mntr_dp #(
    .VOICES_PER_GROUP (VOICES_PER_GROUP)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word),
    .out_last (out_last)
  );

  assign out_tdata = out_word;
  assign out_tlast = out_last;

  `MNTR_ASSERT_NEVER(a_no_overlap, in_tready && out_tvalid, "input taken while a write is pending")
  `MNTR_ASSERT_NEXT(a_pair_follows, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast, "second write does not follow the first")
  `MNTR_ASSERT_IMP(a_sq_addr, out_tvalid && out_word.target_chip != FM_CHIP, out_word.reg_address <= 6'd5, "square-wave write outside the tone registers")
  `MNTR_ASSERT_IMP(a_div_in_wait, stat.div_done, u_ctrl.state_r == ST_DIV, "divider finished outside its wait state")

endmodule
